>>> design/rti_pkg.sv
// rti_pkg: widths, register indexes and the quotient fix-up for the ray/triangle tester
// no dependencies; used by the interfaces, rti_div and ray_triangle_intersect
package rti_pkg;

	// number format
	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;

	// edge, offset and cross-product operand widths
	localparam int EW    = COORD_BITS + 1;
	localparam int PN_W  = 2 * EW;
	localparam int NW    = PN_W + 1;

	// split of the wide dot-product operand into two narrower multiplies
	localparam int LO_W  = (NW + 1) / 2;
	localparam int HI_W  = NW - LO_W;
	localparam int LOP_W = LO_W + 1 + EW;
	localparam int HIP_W = HI_W + EW;
	localparam int PW    = NW + EW;
	localparam int SW    = PW + 2;

	// divider widths
	localparam int QB    = COORD_BITS + 1;
	localparam int RW    = SW + QB;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

	typedef struct packed {
		logic hit;
		logic degenerate;
		logic neg_b;
		logic neg_g;
		logic neg_t;
	} meta_t;

	typedef struct packed {
		logic                  sat;
		logic [COORD_BITS-1:0] val;
	} qres_t;

	// clip an unsigned quotient magnitude to the signed range and apply the sign
	function automatic qres_t fix_quot(logic [QB-1:0] mag, logic big, logic neg);
		logic [QB-1:0] lim;
		logic [QB-1:0] m;
		qres_t         r;
		lim = QB'(1) << (COORD_BITS - 1);
		if (!neg) begin
			lim = lim - QB'(1);
		end
		m     = mag;
		r.sat = 1'b0;
		if (big || (mag > lim)) begin
			m     = lim;
			r.sat = 1'b1;
		end
		if (neg) begin
			m = QB'(0) - m;
		end
		r.val = m[COORD_BITS-1:0];
		return r;
	endfunction

endpackage

>>> design/rti_tri_if.sv
// rti_tri_if: triangle input channel, three vertices per transaction
// depends on rti_pkg
interface rti_tri_if;
	logic valid;
	logic ready;
	logic signed [rti_pkg::COORD_BITS-1:0] v0_x, v0_y, v0_z;
	logic signed [rti_pkg::COORD_BITS-1:0] v1_x, v1_y, v1_z;
	logic signed [rti_pkg::COORD_BITS-1:0] v2_x, v2_y, v2_z;

	modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
		v2_x, v2_y, v2_z, input ready);
	modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
		v2_x, v2_y, v2_z, output ready);
endinterface

>>> design/rti_res_if.sv
// rti_res_if: intersection result channel, one transaction per triangle
// depends on rti_pkg
interface rti_res_if;
	logic valid;
	logic ready;
	logic hit;
	logic degenerate;
	logic signed [rti_pkg::COORD_BITS-1:0] distance_t;
	logic signed [rti_pkg::COORD_BITS-1:0] bary_beta;
	logic signed [rti_pkg::COORD_BITS-1:0] bary_gamma;
	logic saturated;

	modport source (output valid, hit, degenerate, distance_t, bary_beta, bary_gamma,
		saturated, input ready);
	modport sink (input valid, hit, degenerate, distance_t, bary_beta, bary_gamma,
		saturated, output ready);
endinterface

>>> design/rti_cfg_if.sv
// rti_cfg_if: register write channel for the ray origin and direction
// depends on rti_pkg
interface rti_cfg_if;
	logic valid;
	logic ready;
	logic [rti_pkg::CFG_IDX_W-1:0] index;
	logic [rti_pkg::COORD_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> design/rti_div.sv
// rti_div: pipelined restoring divider, one quotient bit per stage, QB + 1 stages
// depends on rti_pkg; quotient of (num << FRAC_BITS) / den with an overflow flag
module rti_div (
	input  logic                   clk,
	input  logic                   en,
	input  logic [rti_pkg::SW-2:0] num,
	input  logic [rti_pkg::SW-2:0] den,
	output logic [rti_pkg::QB-1:0] quot,
	output logic                   big
);

	logic [rti_pkg::RW-1:0]   rem_sd [rti_pkg::QB+1];
	logic [rti_pkg::SW-2:0]   den_sd [rti_pkg::QB+1];
	logic [rti_pkg::QB-1:0]   quo_sd [rti_pkg::QB+1];
	logic                     big_sd [rti_pkg::QB+1];
	logic [rti_pkg::RW-1:0]   x_in;

	assign x_in = rti_pkg::RW'({num, {rti_pkg::FRAC_BITS{1'b0}}});

	// setup stage: flag quotients that need more than QB bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_sd[0] <= x_in;
			den_sd[0] <= den;
			quo_sd[0] <= '0;
			big_sd[0] <= x_in >= (rti_pkg::RW'(den) << rti_pkg::QB);
		end
	end

	// one trial subtraction per stage, most significant quotient bit first
	for (genvar i = 1; i <= rti_pkg::QB; i++) begin : g_step
		localparam int K = rti_pkg::QB - i;
		logic [rti_pkg::RW:0] trial;

		assign trial = {1'b0, rem_sd[i-1]} - {1'b0, (rti_pkg::RW'(den_sd[i-1]) << K)};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[i] <= trial[rti_pkg::RW] ? rem_sd[i-1] : trial[rti_pkg::RW-1:0];
				den_sd[i] <= den_sd[i-1];
				quo_sd[i] <= quo_sd[i-1] | (rti_pkg::QB'(!trial[rti_pkg::RW]) << K);
				big_sd[i] <= big_sd[i-1];
			end
		end
	end

	assign quot = quo_sd[rti_pkg::QB];
	assign big  = big_sd[rti_pkg::QB];

endmodule

>>> design/ray_triangle_intersect.sv
// ray_triangle_intersect: fixed-point ray/triangle hit test, barycentric form
// depends on rti_pkg, rti_tri_if, rti_res_if, rti_cfg_if and rti_div
//
// Usage:
//  cfg carries register writes (index 0..2 ray origin, 3..5 ray direction, Q16.16);
//  ready is always high and writes to other indexes are dropped. Write only while
//  no triangle is in flight.
//  triangle takes one triangle per transaction, result returns one result per
//  triangle in the same order.
//  From accepting a triangle to result valid, a triangle passes seven arithmetic
//  stages (edges, cross products, split dot products, sums, sign fix), a 34-stage
//  divider (one quotient bit per stage, three dividers side by side) and the
//  output register.
//  Throughput is one triangle per cycle while result is taken.
//  When the receiver stalls the whole pipeline holds; triangle.ready follows the
//  output register, so nothing is dropped or repeated.
//  Reset clears all valid bits and loads origin 0 and direction (0, 0, 1.0).
module ray_triangle_intersect (
	input  logic      clk,
	input  logic      arst_n,
	rti_tri_if.sink   triangle,
	rti_res_if.source result,
	rti_cfg_if.sink   cfg
);

	localparam int NPROD = 12;

	// configuration registers
	logic signed [rti_pkg::COORD_BITS-1:0] origin_q [3];
	logic signed [rti_pkg::COORD_BITS-1:0] dir_q    [3];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q[0] <= '0;
			origin_q[1] <= '0;
			origin_q[2] <= '0;
			dir_q[0]    <= '0;
			dir_q[1]    <= '0;
			dir_q[2]    <= rti_pkg::COORD_BITS'(1) << rti_pkg::FRAC_BITS;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				rti_pkg::REG_ORIGIN_X: origin_q[0] <= cfg.data;
				rti_pkg::REG_ORIGIN_Y: origin_q[1] <= cfg.data;
				rti_pkg::REG_ORIGIN_Z: origin_q[2] <= cfg.data;
				rti_pkg::REG_DIR_X:    dir_q[0]    <= cfg.data;
				rti_pkg::REG_DIR_Y:    dir_q[1]    <= cfg.data;
				rti_pkg::REG_DIR_Z:    dir_q[2]    <= cfg.data;
				default: ;
			endcase
		end
	end

	// global advance: everything moves when the output register can take data
	logic res_v_q;
	logic en;

	assign en             = !res_v_q || result.ready;
	assign triangle.ready = en;

	logic signed [rti_pkg::COORD_BITS-1:0] v0 [3];
	logic signed [rti_pkg::COORD_BITS-1:0] v1 [3];
	logic signed [rti_pkg::COORD_BITS-1:0] v2 [3];
	logic signed [rti_pkg::EW-1:0]         dirx [3];

	assign v0[0] = triangle.v0_x;
	assign v0[1] = triangle.v0_y;
	assign v0[2] = triangle.v0_z;
	assign v1[0] = triangle.v1_x;
	assign v1[1] = triangle.v1_y;
	assign v1[2] = triangle.v1_z;
	assign v2[0] = triangle.v2_x;
	assign v2[1] = triangle.v2_y;
	assign v2[2] = triangle.v2_z;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= triangle.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// stage 1: edges and origin offset
	logic signed [rti_pkg::EW-1:0] e0_s1 [3], e1_s1 [3], w_s1 [3];
	logic signed [rti_pkg::EW-1:0] e0_s2 [3], e1_s2 [3], w_s2 [3];
	logic signed [rti_pkg::EW-1:0] e0_s3 [3], e1_s3 [3], w_s3 [3];
	logic signed [rti_pkg::PN_W-1:0] pn_s2 [6], pc_s2 [6];
	logic signed [rti_pkg::NW-1:0]   n_s3 [3], c_s3 [3];

	for (genvar i = 0; i < 3; i++) begin : g_vec
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;

		assign dirx[i] = rti_pkg::EW'(dir_q[i]);

		always_ff @(posedge clk) begin
			if (en) begin
				e0_s1[i] <= rti_pkg::EW'(v1[i]) - rti_pkg::EW'(v0[i]);
				e1_s1[i] <= rti_pkg::EW'(v0[i]) - rti_pkg::EW'(v2[i]);
				w_s1[i]  <= rti_pkg::EW'(v0[i]) - rti_pkg::EW'(origin_q[i]);
			end
		end

		// stage 2: cross-product terms of n = e1 x e0 and c = dir x w
		always_ff @(posedge clk) begin
			if (en) begin
				pn_s2[2*i]   <= e1_s1[J] * e0_s1[K];
				pn_s2[2*i+1] <= e1_s1[K] * e0_s1[J];
				pc_s2[2*i]   <= dirx[J] * w_s1[K];
				pc_s2[2*i+1] <= dirx[K] * w_s1[J];
				e0_s2[i]     <= e0_s1[i];
				e1_s2[i]     <= e1_s1[i];
				w_s2[i]      <= w_s1[i];
			end
		end

		// stage 3: cross-product differences
		always_ff @(posedge clk) begin
			if (en) begin
				n_s3[i]  <= rti_pkg::NW'(pn_s2[2*i]) - rti_pkg::NW'(pn_s2[2*i+1]);
				c_s3[i]  <= rti_pkg::NW'(pc_s2[2*i]) - rti_pkg::NW'(pc_s2[2*i+1]);
				e0_s3[i] <= e0_s2[i];
				e1_s3[i] <= e1_s2[i];
				w_s3[i]  <= w_s2[i];
			end
		end
	end

	// operand pairs of the four dot products: n.dir, c.e1, c.e0, n.w
	logic signed [rti_pkg::NW-1:0]    opa [NPROD];
	logic signed [rti_pkg::EW-1:0]    opb [NPROD];
	logic signed [rti_pkg::LOP_W-1:0] lo_s4 [NPROD];
	logic signed [rti_pkg::HIP_W-1:0] hi_s4 [NPROD];
	logic signed [rti_pkg::PW-1:0]    prod_s5 [NPROD];

	for (genvar i = 0; i < 3; i++) begin : g_ops
		assign opa[i]     = n_s3[i];
		assign opb[i]     = dirx[i];
		assign opa[3 + i] = c_s3[i];
		assign opb[3 + i] = e1_s3[i];
		assign opa[6 + i] = c_s3[i];
		assign opb[6 + i] = e0_s3[i];
		assign opa[9 + i] = n_s3[i];
		assign opb[9 + i] = w_s3[i];
	end

	for (genvar j = 0; j < NPROD; j++) begin : g_prod
		// stage 4: low and high partial products
		always_ff @(posedge clk) begin
			if (en) begin
				lo_s4[j] <= $signed({1'b0, opa[j][rti_pkg::LO_W-1:0]}) * opb[j];
				hi_s4[j] <= $signed(opa[j][rti_pkg::NW-1:rti_pkg::LO_W]) * opb[j];
			end
		end

		// stage 5: recombine the partial products
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s5[j] <= (rti_pkg::PW'(hi_s4[j]) <<< rti_pkg::LO_W) + rti_pkg::PW'(lo_s4[j]);
			end
		end
	end

	// stage 6: dot-product sums
	logic signed [rti_pkg::SW-1:0] d_s6, nb_s6, ng_s6, nt_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s6  <= rti_pkg::SW'(prod_s5[0]) + rti_pkg::SW'(prod_s5[1]) + rti_pkg::SW'(prod_s5[2]);
			nb_s6 <= rti_pkg::SW'(prod_s5[3]) + rti_pkg::SW'(prod_s5[4]) + rti_pkg::SW'(prod_s5[5]);
			ng_s6 <= rti_pkg::SW'(prod_s5[6]) + rti_pkg::SW'(prod_s5[7]) + rti_pkg::SW'(prod_s5[8]);
			nt_s6 <= rti_pkg::SW'(prod_s5[9]) + rti_pkg::SW'(prod_s5[10]) + rti_pkg::SW'(prod_s5[11]);
		end
	end

	// stage 7: make the denominator positive, sign-adjust the beta and gamma numerators, take t's magnitude and sign
	logic                          dneg;
	logic signed [rti_pkg::SW-1:0] ad_s7, ab_s7, ag_s7;
	logic        [rti_pkg::SW-1:0] tmag_s7;
	logic                          deg_s7, negt_s7;

	assign dneg = d_s6[rti_pkg::SW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			ad_s7   <= dneg ? -d_s6 : d_s6;
			ab_s7   <= dneg ? -nb_s6 : nb_s6;
			ag_s7   <= dneg ? -ng_s6 : ng_s6;
			tmag_s7 <= nt_s6[rti_pkg::SW-1] ? -nt_s6 : nt_s6;
			negt_s7 <= nt_s6[rti_pkg::SW-1] ^ dneg;
			deg_s7  <= (d_s6 == '0);
		end
	end

	// exact inside test on the sign-adjusted numerators
	logic signed [rti_pkg::SW:0]   bg_sum;
	logic signed [rti_pkg::SW+1:0] slack;
	rti_pkg::meta_t                meta_in;
	logic [rti_pkg::SW-2:0]        bmag, gmag;

	assign bg_sum = (rti_pkg::SW+1)'(ab_s7) + (rti_pkg::SW+1)'(ag_s7);
	assign slack  = (rti_pkg::SW+2)'(ad_s7) - (rti_pkg::SW+2)'(bg_sum);
	assign bmag   = ab_s7[rti_pkg::SW-1] ? (rti_pkg::SW-1)'(-ab_s7) : ab_s7[rti_pkg::SW-2:0];
	assign gmag   = ag_s7[rti_pkg::SW-1] ? (rti_pkg::SW-1)'(-ag_s7) : ag_s7[rti_pkg::SW-2:0];

	always_comb begin
		meta_in.hit        = !ab_s7[rti_pkg::SW-1] && !ag_s7[rti_pkg::SW-1]
			&& !slack[rti_pkg::SW+1];
		meta_in.degenerate = deg_s7;
		meta_in.neg_b      = ab_s7[rti_pkg::SW-1];
		meta_in.neg_g      = ag_s7[rti_pkg::SW-1];
		meta_in.neg_t      = negt_s7;
	end

	// dividers for beta, gamma and t
	logic [rti_pkg::QB-1:0] qb_mag, qg_mag, qt_mag;
	logic                   qb_big, qg_big, qt_big;

	rti_div u_div_b (
		.clk  (clk),
		.en   (en),
		.num  (bmag),
		.den  (ad_s7[rti_pkg::SW-2:0]),
		.quot (qb_mag),
		.big  (qb_big)
	);

	rti_div u_div_g (
		.clk  (clk),
		.en   (en),
		.num  (gmag),
		.den  (ad_s7[rti_pkg::SW-2:0]),
		.quot (qg_mag),
		.big  (qg_big)
	);

	rti_div u_div_t (
		.clk  (clk),
		.en   (en),
		.num  (tmag_s7[rti_pkg::SW-2:0]),
		.den  (ad_s7[rti_pkg::SW-2:0]),
		.quot (qt_mag),
		.big  (qt_big)
	);

	// flags and valid bits that travel alongside the dividers
	rti_pkg::meta_t meta_sd [rti_pkg::QB+1];
	logic [rti_pkg::QB:0] vd_sd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_sd <= '0;
		end else if (en) begin
			vd_sd <= {vd_sd[rti_pkg::QB-1:0], v_s7};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_sd[0] <= meta_in;
		end
	end

	for (genvar i = 1; i <= rti_pkg::QB; i++) begin : g_meta
		always_ff @(posedge clk) begin
			if (en) begin
				meta_sd[i] <= meta_sd[i-1];
			end
		end
	end

	// saturation, sign and the miss / degenerate cases
	rti_pkg::meta_t mt;
	rti_pkg::qres_t rb, rg, rt;

	assign mt = meta_sd[rti_pkg::QB];
	assign rb = rti_pkg::fix_quot(qb_mag, qb_big, mt.neg_b);
	assign rg = rti_pkg::fix_quot(qg_mag, qg_big, mt.neg_g);
	assign rt = rti_pkg::fix_quot(qt_mag, qt_big, mt.neg_t);

	// output register
	logic                                  hit_q, deg_q, sat_q;
	logic signed [rti_pkg::COORD_BITS-1:0] t_q, beta_q, gamma_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (en) begin
			res_v_q <= vd_sd[rti_pkg::QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (mt.degenerate) begin
				hit_q   <= 1'b0;
				deg_q   <= 1'b1;
				t_q     <= '0;
				beta_q  <= '0;
				gamma_q <= '0;
				sat_q   <= 1'b0;
			end else begin
				hit_q   <= mt.hit;
				deg_q   <= 1'b0;
				t_q     <= mt.hit ? rt.val : '0;
				beta_q  <= rb.val;
				gamma_q <= rg.val;
				sat_q   <= rb.sat || rg.sat || (mt.hit && rt.sat);
			end
		end
	end

	assign result.valid      = res_v_q;
	assign result.hit        = hit_q;
	assign result.degenerate = deg_q;
	assign result.distance_t = t_q;
	assign result.bary_beta  = beta_q;
	assign result.bary_gamma = gamma_q;
	assign result.saturated  = sat_q;

endmodule

>>> bench/rti_checker.sv
`timescale 1ns / 1ps
// rti_checker: predicts each intersection result from the triangle and ray registers
// and compares it with the result channel; depends on rti_pkg and the rti_*_if interfaces
module rti_checker (
	input  logic       clk,
	input  logic       arst_n,
	rti_tri_if.sink    triangle,
	rti_res_if.sink    result,
	rti_cfg_if.sink    cfg,
	output int         fail_count,
	output int         pending
);

	typedef logic signed [255:0] wide_t;

	typedef struct packed {
		logic                                  hit;
		logic                                  degenerate;
		logic signed [rti_pkg::COORD_BITS-1:0] distance_t;
		logic signed [rti_pkg::COORD_BITS-1:0] bary_beta;
		logic signed [rti_pkg::COORD_BITS-1:0] bary_gamma;
		logic                                  saturated;
	} hit_result_t;

	logic signed [rti_pkg::COORD_BITS-1:0] ray_regs [6];
	hit_result_t                           hit_queue [$];

	// fixed-point quotient, truncated toward zero and clipped to the signed range
	function automatic logic [rti_pkg::COORD_BITS-1:0] clip_quot(wide_t num, wide_t den,
		inout logic sat);
		logic  neg;
		wide_t q;
		wide_t lim;
		neg = (num < 0) != (den < 0);
		if (num < 0) num = -num;
		if (den < 0) den = -den;
		q   = (num <<< rti_pkg::FRAC_BITS) / den;
		lim = wide_t'(1) <<< (rti_pkg::COORD_BITS - 1);
		if (!neg) lim = lim - 1;
		if (q > lim) begin
			q   = lim;
			sat = 1'b1;
		end
		if (neg) q = -q;
		return q[rti_pkg::COORD_BITS-1:0];
	endfunction

	// full-precision ray/triangle test against the current ray registers
	function automatic hit_result_t predict_hit(wide_t v [9]);
		wide_t       e0 [3], e1 [3], nrm [3], w [3], c [3], o [3], d [3];
		wide_t       det, nb, ng, nt, ab, ag, ad;
		logic        sat;
		hit_result_t r;
		for (int i = 0; i < 3; i++) begin
			o[i]  = ray_regs[i];
			d[i]  = ray_regs[3+i];
			e0[i] = v[3+i] - v[i];
			e1[i] = v[i] - v[6+i];
			w[i]  = v[i] - o[i];
		end
		nrm[0] = e1[1] * e0[2] - e1[2] * e0[1];
		nrm[1] = e1[2] * e0[0] - e1[0] * e0[2];
		nrm[2] = e1[0] * e0[1] - e1[1] * e0[0];
		c[0]   = d[1] * w[2] - d[2] * w[1];
		c[1]   = d[2] * w[0] - d[0] * w[2];
		c[2]   = d[0] * w[1] - d[1] * w[0];
		det    = nrm[0] * d[0] + nrm[1] * d[1] + nrm[2] * d[2];
		r      = '0;
		if (det == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		nb  = c[0] * e1[0] + c[1] * e1[1] + c[2] * e1[2];
		ng  = c[0] * e0[0] + c[1] * e0[1] + c[2] * e0[2];
		nt  = nrm[0] * w[0] + nrm[1] * w[1] + nrm[2] * w[2];
		sat = 1'b0;
		r.bary_beta  = clip_quot(nb, det, sat);
		r.bary_gamma = clip_quot(ng, det, sat);
		ab = (det < 0) ? -nb : nb;
		ag = (det < 0) ? -ng : ng;
		ad = (det < 0) ? -det : det;
		r.hit = (ab >= 0) && (ag >= 0) && (ab + ag <= ad);
		if (r.hit) r.distance_t = clip_quot(nt, det, sat);
		r.saturated = sat;
		return r;
	endfunction

	assign pending = hit_queue.size();

	always @(posedge clk or negedge arst_n) begin
		wide_t       verts [9];
		hit_result_t exp_r;
		hit_result_t got;
		if (!arst_n) begin
			foreach (ray_regs[i])
				ray_regs[i] <= (i == int'(rti_pkg::REG_DIR_Z))
					? rti_pkg::COORD_BITS'(1) <<< rti_pkg::FRAC_BITS : '0;
			hit_queue.delete();
			fail_count <= 0;
		end else begin
			// register write transaction
			if (cfg.valid && cfg.ready && cfg.index <= rti_pkg::REG_DIR_Z)
				ray_regs[cfg.index] <= cfg.data;
			// triangle transaction: predict
			if (triangle.valid && triangle.ready) begin
				verts = '{triangle.v0_x, triangle.v0_y, triangle.v0_z,
					triangle.v1_x, triangle.v1_y, triangle.v1_z,
					triangle.v2_x, triangle.v2_y, triangle.v2_z};
				hit_queue.push_back(predict_hit(verts));
			end
			// result transaction: compare with oldest prediction
			if (result.valid && result.ready) begin
				got = '{result.hit, result.degenerate, result.distance_t,
					result.bary_beta, result.bary_gamma, result.saturated};
				if (hit_queue.size() == 0) begin
					$display("%0t: unexpected result %p", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = hit_queue.pop_front();
					if (got !== exp_r) begin
						$display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for ray_triangle_intersect
// depends on rti_pkg, the rti_*_if interfaces and rti_checker
module tb;

	localparam int LATENCY   = 42;
	localparam int WDOG_MAX  = 5000;
	localparam int HOLD_CYC  = 300;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   send_idle_pct;
	int   recv_idle_pct;
	bit   recv_hold;
	int   idle_cycles = 0;

	rti_tri_if triangle ();
	rti_res_if result ();
	rti_cfg_if cfg ();

	ray_triangle_intersect u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.triangle (triangle.sink),
		.result   (result.source),
		.cfg      (cfg.sink)
	);

	rti_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.triangle   (triangle.sink),
		.result     (result.sink),
		.cfg        (cfg.sink),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// coordinate mix: extremes, small values, near-unit values and full random
	function automatic logic [rti_pkg::COORD_BITS-1:0] pick_coord();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(signed'($urandom_range(0, 8)) - 4) <<< rti_pkg::FRAC_BITS;
			3: return $urandom();
			4, 5: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
		endcase
	endfunction

	// valid stays high after the transaction; an idle gap or drain drops it
	task automatic send_tri(logic [rti_pkg::COORD_BITS-1:0] v [9]);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			triangle.valid <= 1'b0;
			@(posedge clk);
		end
		triangle.valid <= 1'b1;
		{triangle.v0_x, triangle.v0_y, triangle.v0_z, triangle.v1_x, triangle.v1_y,
			triangle.v1_z, triangle.v2_x, triangle.v2_y, triangle.v2_z} <=
			{v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
		@(posedge clk);
		while (!triangle.ready) @(posedge clk);
	endtask

	task automatic write_reg(logic [rti_pkg::CFG_IDX_W-1:0] idx,
		logic [rti_pkg::COORD_BITS-1:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		triangle.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// random triangles: small coordinates around zero, or pick_coord values
	task automatic send_random(int count);
		logic [rti_pkg::COORD_BITS-1:0] v [9];
		int                             s;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 2) != 0) begin
				s = $urandom_range(0, 3);
				foreach (v[i])
					v[i] = 32'(int'($urandom_range(0, 1 << (16 + 2 * s)))
						- (1 << (15 + 2 * s)));
			end else begin
				foreach (v[i]) v[i] = pick_coord();
				if ($urandom_range(0, 5) == 0) v[3:5] = v[0:2];
			end
			send_tri(v);
		end
	endtask

	// receiver ready: random idling plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			result.ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog on accepted transactions
	always @(posedge clk) begin
		if ((triangle.valid && triangle.ready) || (result.valid && result.ready)
			|| (cfg.valid && cfg.ready) || recv_hold)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WDOG_MAX) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [rti_pkg::COORD_BITS-1:0] v [9];
		logic [rti_pkg::COORD_BITS-1:0] unit;
		unit           = 1 << rti_pkg::FRAC_BITS;
		recv_hold      = 1'b0;
		send_idle_pct  = 0;
		recv_idle_pct  = 0;
		triangle.valid = 1'b0;
		{triangle.v0_x, triangle.v0_y, triangle.v0_z, triangle.v1_x, triangle.v1_y,
			triangle.v1_z, triangle.v2_x, triangle.v2_y, triangle.v2_z} = '0;
		cfg.valid      = 1'b0;
		cfg.index      = '0;
		cfg.data       = '0;
		arst_n         = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: default ray down z
		v = '{0, 0, unit, unit, 0, unit, 0, unit, unit};
		send_tri(v); // plain hit
		v = '{0, 0, -unit, unit, 0, -unit, 0, unit, -unit};
		send_tri(v); // hit behind origin
		v = '{unit, unit, unit, 2*unit, unit, unit, unit, 2*unit, unit};
		send_tri(v); // miss
		v = '{0, 0, 0, unit, 0, 0, 2*unit, 0, 0};
		send_tri(v); // flat triangle, zero determinant
		v = '{0, 0, 0, 0, 0, unit, 0, unit, 0};
		send_tri(v); // parallel to ray
		v = '{0, 0, unit, 1, 0, unit, 0, 1, unit};
		send_tri(v); // tiny triangle, ray through the first vertex
		v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000};
		send_tri(v); // extreme corners
		v = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
		send_tri(v);
		v = '{unit, 0, unit, 0, unit, unit, 0, 0, unit};
		send_tri(v); // vertex order rotated, ray through the third vertex
		v = '{0, 0, unit, 2*unit, 0, unit, 0, 2*unit, unit};
		send_tri(v); // ray on the corner, edge case of the exact test
		drain();

		// extreme ray registers, out-of-range index is ignored
		write_reg(rti_pkg::REG_ORIGIN_X, 32'h7fff_ffff);
		write_reg(rti_pkg::REG_ORIGIN_Y, 32'h8000_0000);
		write_reg(rti_pkg::REG_ORIGIN_Z, 32'hffff_ffff);
		write_reg(rti_pkg::REG_DIR_X, 32'h8000_0000);
		write_reg(rti_pkg::REG_DIR_Y, 32'h7fff_ffff);
		write_reg(rti_pkg::REG_DIR_Z, 32'h0000_0001);
		write_reg(3'd6, 32'h1234_5678);
		write_reg(3'd7, 32'hdead_beef);
		for (int k = 0; k < 6; k++) begin
			foreach (v[i]) v[i] = pick_coord();
			send_tri(v);
		end
		drain();

		// random phases, each with its own ray
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 60 : 0;
			recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 15 : 0;
			write_reg(rti_pkg::REG_ORIGIN_X, pick_coord());
			write_reg(rti_pkg::REG_ORIGIN_Y, pick_coord());
			write_reg(rti_pkg::REG_ORIGIN_Z,
				32'(int'($urandom_range(0, 1 << 20)) - (1 << 19)));
			write_reg(rti_pkg::REG_DIR_X, 32'(int'($urandom_range(0, 1 << 17)) - (1 << 16)));
			write_reg(rti_pkg::REG_DIR_Y, 32'(int'($urandom_range(0, 1 << 17)) - (1 << 16)));
			write_reg(rti_pkg::REG_DIR_Z, (ph == 2) ? pick_coord() : unit);
			if (ph == 2) begin
				// long receiver hold-off while triangles keep coming
				fork
					begin
						recv_hold = 1'b1;
						repeat (HOLD_CYC) @(posedge clk);
						recv_hold = 1'b0;
					end
					send_random(120);
				join
			end
			send_random(300);
			drain();
		end

		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

>>> sim.f
design/rti_pkg.sv
design/rti_tri_if.sv
design/rti_res_if.sv
design/rti_cfg_if.sv
design/rti_div.sv
design/ray_triangle_intersect.sv
bench/rti_checker.sv
bench/tb.sv
